>>> hdl/q8sf_pkg.sv
package q8sf_pkg;

  localparam int IN_W  = 17;
  localparam int OUT_W = 19;
  localparam int IDX_W = 3;

  // corners first, then mid-edge nodes
  localparam logic [IDX_W-1:0] NODE_C_LL  = 3'd0;
  localparam logic [IDX_W-1:0] NODE_C_LR  = 3'd1;
  localparam logic [IDX_W-1:0] NODE_C_UR  = 3'd2;
  localparam logic [IDX_W-1:0] NODE_C_UL  = 3'd3;
  localparam logic [IDX_W-1:0] NODE_M_BOT = 3'd4;
  localparam logic [IDX_W-1:0] NODE_M_RGT = 3'd5;
  localparam logic [IDX_W-1:0] NODE_M_TOP = 3'd6;
  localparam logic [IDX_W-1:0] NODE_M_LFT = 3'd7;
  localparam logic [IDX_W-1:0] NODE_LAST  = NODE_M_LFT;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } node_ctrl_t;

  function automatic logic is_corner(input logic [IDX_W-1:0] idx);
    return idx < NODE_M_BOT;
  endfunction

endpackage

>>> hdl/q8sf_if.sv
interface q8sf_point_if;
  import q8sf_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] pcoord_r;
  logic [IN_W-1:0] pcoord_s;
  modport source(output valid, pcoord_r, pcoord_s, input ready);
  modport sink(input valid, pcoord_r, pcoord_s, output ready);
endinterface

interface q8sf_node_if;
  import q8sf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        node_index;
  logic signed [OUT_W-1:0] node_weight;
  logic signed [OUT_W-1:0] deriv_r;
  logic signed [OUT_W-1:0] deriv_s;
  logic                    last_node;
  modport source(output valid, node_index, node_weight, deriv_r, deriv_s, last_node,
                 input ready);
  modport sink(input valid, node_index, node_weight, deriv_r, deriv_s, last_node,
               output ready);
endinterface

>>> hdl/q8sf_seq.sv
module q8sf_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  q8sf_point_if.sink                 point_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output q8sf_pkg::node_ctrl_t       job_ctrl_o,
  output logic signed [FRAC_BITS+2:0] x0_o,
  output logic signed [FRAC_BITS+2:0] y0_o,
  output logic signed [FRAC_BITS+2:0] x1_o,
  output logic signed [FRAC_BITS+2:0] y1_o,
  output logic signed [FRAC_BITS+2:0] x2_o,
  output logic signed [FRAC_BITS+2:0] y2_o,
  output logic signed [FRAC_BITS+2:0] z_o
);
  import q8sf_pkg::*;

  localparam int OW = FRAC_BITS + 3;
  localparam int EW = (IN_W > FRAC_BITS + 2) ? IN_W + 1 : FRAC_BITS + 2;
  localparam logic [EW-1:0] ONE_U = {{(EW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [OW-1:0] ONE_S = {3'b001, {FRAC_BITS{1'b0}}};

  // saturate to one, then map 0..1 onto -1..1
  function automatic logic signed [OW-1:0] to_rs(input logic [IN_W-1:0] p);
    logic [EW-1:0] pe;
    pe = {{(EW-IN_W){1'b0}}, p};
    if (pe > ONE_U) begin
      pe = ONE_U;
    end
    return $signed({1'b0, pe[FRAC_BITS:0], 1'b0}) - ONE_S;
  endfunction

  logic                 busy_q;
  logic [IDX_W-1:0]     cnt_q;
  logic signed [OW-1:0] r_q, s_q;
  logic                 job_valid_q;
  node_ctrl_t           job_ctrl_q;
  logic signed [OW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, z_q;

  logic                 job_rdy, issue, last_issue, take;
  logic                 ri_n, si_n;
  logic signed [OW-1:0] a, b, u, w;
  logic signed [OW-1:0] x0_d, y0_d, x1_d, y1_d, x2_d, y2_d, z_d;

  assign job_rdy       = !job_valid_q || job_ready_i;
  assign issue         = busy_q && job_rdy;
  assign last_issue    = issue && (cnt_q == NODE_LAST);
  assign point_i.ready = !busy_q || last_issue;
  assign take          = point_i.valid && point_i.ready;

  always_comb begin
    case (cnt_q)
      NODE_C_LL: begin ri_n = 1'b1; si_n = 1'b1; end
      NODE_C_LR: begin ri_n = 1'b0; si_n = 1'b1; end
      NODE_C_UR: begin ri_n = 1'b0; si_n = 1'b0; end
      NODE_C_UL: begin ri_n = 1'b1; si_n = 1'b0; end
      default:   begin ri_n = 1'b0; si_n = 1'b0; end
    endcase
    a    = ri_n ? -r_q : r_q;
    b    = si_n ? -s_q : s_q;
    u    = ONE_S + a;
    w    = ONE_S + b;
    x0_d = u;
    y0_d = w;
    x1_d = ri_n ? -w : w;
    y1_d = (a <<< 1) + b;
    x2_d = si_n ? -u : u;
    y2_d = a + (b <<< 1);
    z_d  = a + b - ONE_S;
    case (cnt_q)
      NODE_M_BOT: begin
        x0_d = r_q;  y0_d = r_q;
        x1_d = -r_q; y1_d = ONE_S - s_q;
        x2_d = '0;   y2_d = '0;
        z_d  = ONE_S - s_q;
      end
      NODE_M_RGT: begin
        x0_d = s_q;  y0_d = s_q;
        x1_d = '0;   y1_d = '0;
        x2_d = -s_q; y2_d = ONE_S + r_q;
        z_d  = ONE_S + r_q;
      end
      NODE_M_TOP: begin
        x0_d = r_q;  y0_d = r_q;
        x1_d = -r_q; y1_d = ONE_S + s_q;
        x2_d = '0;   y2_d = '0;
        z_d  = ONE_S + s_q;
      end
      NODE_M_LFT: begin
        x0_d = s_q;  y0_d = s_q;
        x1_d = '0;   y1_d = '0;
        x2_d = -s_q; y2_d = ONE_S - r_q;
        z_d  = ONE_S - r_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (issue) begin
        busy_q <= !last_issue;
        cnt_q  <= cnt_q + 1'b1;
      end
      if (job_rdy) begin
        job_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      r_q <= to_rs(point_i.pcoord_r);
      s_q <= to_rs(point_i.pcoord_s);
    end
    if (issue) begin
      job_ctrl_q.idx  <= cnt_q;
      job_ctrl_q.last <= (cnt_q == NODE_LAST);
      x0_q <= x0_d;
      y0_q <= y0_d;
      x1_q <= x1_d;
      y1_q <= y1_d;
      x2_q <= x2_d;
      y2_q <= y2_d;
      z_q  <= z_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_ctrl_o  = job_ctrl_q;
  assign x0_o        = x0_q;
  assign y0_o        = y0_q;
  assign x1_o        = x1_q;
  assign y1_o        = y1_q;
  assign x2_o        = x2_q;
  assign y2_o        = y2_q;
  assign z_o         = z_q;

endmodule

>>> hdl/q8sf_dsp.sv
module q8sf_dsp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  q8sf_pkg::node_ctrl_t        job_ctrl_i,
  input  logic signed [FRAC_BITS+2:0] x0_i,
  input  logic signed [FRAC_BITS+2:0] y0_i,
  input  logic signed [FRAC_BITS+2:0] x1_i,
  input  logic signed [FRAC_BITS+2:0] y1_i,
  input  logic signed [FRAC_BITS+2:0] x2_i,
  input  logic signed [FRAC_BITS+2:0] y2_i,
  input  logic signed [FRAC_BITS+2:0] z_i,
  q8sf_node_if.source                 node_o
);
  import q8sf_pkg::*;

  localparam int OW = FRAC_BITS + 3;
  localparam int PW = 2 * OW;
  localparam int SW = OW + OUT_W;
  localparam logic signed [OW-1:0] ONE_S = {3'b001, {FRAC_BITS{1'b0}}};
  localparam logic signed [OW:0]   HALF_RND = {{OW{1'b0}}, 1'b1};
  localparam logic signed [PW-1:0] RH0 = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RH1 = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [PW-1:0] RH2 = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic signed [SW-1:0] SAT_HI = {{(OW+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(OW+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // round to nearest, halves up
  function automatic logic signed [OW-1:0] rnd_sh0(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + RH0) >>> FRAC_BITS;
    return t[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] rnd_sh1(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + RH1) >>> (FRAC_BITS + 1);
    return t[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] rnd_sh2(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + RH2) >>> (FRAC_BITS + 2);
    return t[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] half(input logic signed [OW-1:0] x);
    logic signed [OW:0] t;
    t = {x[OW-1], x};
    t = (t + HALF_RND) >>> 1;
    return t[OW-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [SW-1:0] e;
    e = {{OUT_W{v[OW-1]}}, v};
    if (e > SAT_HI) begin
      e = SAT_HI;
    end else if (e < SAT_LO) begin
      e = SAT_LO;
    end
    return e[OUT_W-1:0];
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  node_ctrl_t c1_q, c2_q, c3_q, c4_q;

  logic signed [PW-1:0]    p0_q, p1_q, p2_q;
  logic signed [OW-1:0]    z1_q;
  logic signed [OW-1:0]    h2_q, dr2_q, ds2_q, z2_q;
  logic signed [PW-1:0]    wp3_q;
  logic signed [OW-1:0]    dr3_q, ds3_q;
  logic signed [OUT_W-1:0] wt4_q, dr4_q, ds4_q;

  logic signed [OW-1:0] h2_d, dr2_d, ds2_d;
  logic signed [OW-1:0] dr3_d, ds3_d, wt4_d;

  assign rdy4        = !v4_q || node_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign job_ready_o = rdy1;

  // first products rescaled; mid nodes form 1 - r^2 or 1 - s^2
  always_comb begin
    if (is_corner(c1_q.idx)) begin
      h2_d  = rnd_sh2(p0_q);
      dr2_d = rnd_sh2(p1_q);
      ds2_d = rnd_sh2(p2_q);
    end else begin
      h2_d  = ONE_S - rnd_sh0(p0_q);
      dr2_d = rnd_sh0(p1_q);
      ds2_d = rnd_sh0(p2_q);
    end
  end

  // derivatives of mid nodes that are a plain halving
  always_comb begin
    dr3_d = dr2_q;
    ds3_d = ds2_q;
    case (c2_q.idx)
      NODE_M_BOT: ds3_d = half(-h2_q);
      NODE_M_RGT: dr3_d = half(h2_q);
      NODE_M_TOP: ds3_d = half(h2_q);
      NODE_M_LFT: dr3_d = half(-h2_q);
      default: begin
      end
    endcase
  end

  always_comb begin
    if (is_corner(c3_q.idx)) begin
      wt4_d = rnd_sh0(wp3_q);
    end else begin
      wt4_d = rnd_sh1(wp3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= job_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      c1_q <= job_ctrl_i;
      p0_q <= x0_i * y0_i;
      p1_q <= x1_i * y1_i;
      p2_q <= x2_i * y2_i;
      z1_q <= z_i;
    end
    if (rdy2) begin
      c2_q  <= c1_q;
      h2_q  <= h2_d;
      dr2_q <= dr2_d;
      ds2_q <= ds2_d;
      z2_q  <= z1_q;
    end
    if (rdy3) begin
      c3_q  <= c2_q;
      wp3_q <= h2_q * z2_q;
      dr3_q <= dr3_d;
      ds3_q <= ds3_d;
    end
    if (rdy4) begin
      c4_q  <= c3_q;
      wt4_q <= sat(wt4_d);
      dr4_q <= sat(dr3_q);
      ds4_q <= sat(ds3_q);
    end
  end

  assign node_o.valid       = v4_q;
  assign node_o.node_index  = c4_q.idx;
  assign node_o.last_node   = c4_q.last;
  assign node_o.node_weight = wt4_q;
  assign node_o.deriv_r     = dr4_q;
  assign node_o.deriv_s     = ds4_q;

endmodule

>>> hdl/quad8_shape_functions.sv
// Eight-node serendipity quad shape functions. Each point word (two Q1.16
// coordinates, saturated to 1.0) yields eight node words, corners 0-3 then
// mid-edge nodes 4-7, each with the weight and its r and s derivatives in
// signed Q2.16, the eighth flagged by last_node. The node counter in the
// sequencer issues one node per cycle while the pipeline accepts; the next
// point is taken in the cycle its predecessor's last node issues, so with a
// ready receiver and points waiting the output streams one word per cycle
// without gaps. The first node word passes through the coordinate register,
// a node-operand register, a multiply stage, a rounding stage, a second
// multiply stage and the output register, which rounds and saturates.
// Backpressure stalls every stage in place.
module quad8_shape_functions #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  q8sf_point_if.sink  point_i,
  q8sf_node_if.source node_o
);
  import q8sf_pkg::*;

  localparam int OW = FRAC_BITS + 3;

  logic                 job_valid, job_ready;
  node_ctrl_t           job_ctrl;
  logic signed [OW-1:0] x0, y0, x1, y1, x2, y2, z;

  q8sf_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_ctrl_o  (job_ctrl),
    .x0_o        (x0),
    .y0_o        (y0),
    .x1_o        (x1),
    .y1_o        (y1),
    .x2_o        (x2),
    .y2_o        (y2),
    .z_o         (z)
  );

  q8sf_dsp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dsp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_ctrl_i  (job_ctrl),
    .x0_i        (x0),
    .y0_i        (y0),
    .x1_i        (x1),
    .y1_i        (y1),
    .x2_i        (x2),
    .y2_i        (y2),
    .z_i         (z),
    .node_o      (node_o)
  );

endmodule

>>> tb/sv/q8sf_node_checker.sv
`timescale 1ns / 1ps

module q8sf_node_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  q8sf_point_if point_i,
  q8sf_node_if  node_i,
  output int    fail_count_o,
  output int    pending_o
);
  import q8sf_pkg::*;

  localparam longint UNIT   = longint'(1) << FRAC_BITS;
  localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [OUT_W-1:0] weight;
    logic signed [OUT_W-1:0] dr;
    logic signed [OUT_W-1:0] ds;
    logic                    last;
  } node_word_t;

  node_word_t node_exp_q[$];
  int         fails = 0;

  // round to nearest, halves toward plus infinity
  function automatic longint round_shift(input longint x, input int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, input int k);
    return round_shift(a * b, k);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint x);
    if (x > OUT_HI) return OUT_W'(OUT_HI);
    if (x < OUT_LO) return OUT_W'(OUT_LO);
    return OUT_W'(x);
  endfunction

  function automatic void predict_shape_set(input logic [IN_W-1:0] pr,
                                            input logic [IN_W-1:0] ps);
    node_word_t       w;
    logic [IDX_W-1:0] idx;
    longint           p, q, rr, ss, ri, si, u, v, t, m, n, nw, nr, ns;
    p = longint'(pr);
    q = longint'(ps);
    if (p > UNIT) p = UNIT;
    if (q > UNIT) q = UNIT;
    rr = 2 * p - UNIT;
    ss = 2 * q - UNIT;
    m  = UNIT - fx_mul(rr, rr, FRAC_BITS);
    n  = UNIT - fx_mul(ss, ss, FRAC_BITS);
    for (int k = 0; k < 8; k++) begin
      idx = IDX_W'(k);
      if (idx < NODE_M_BOT) begin
        ri = (idx == NODE_C_LR || idx == NODE_C_UR) ? 1 : -1;
        si = (idx == NODE_C_UR || idx == NODE_C_UL) ? 1 : -1;
        u  = UNIT + ri * rr;
        v  = UNIT + si * ss;
        t  = fx_mul(u, v, FRAC_BITS + 2);
        nw = fx_mul(t, ri * rr + si * ss - UNIT, FRAC_BITS);
        nr = fx_mul(ri * v, 2 * ri * rr + si * ss, FRAC_BITS + 2);
        ns = fx_mul(si * u, ri * rr + 2 * si * ss, FRAC_BITS + 2);
      end else begin
        case (idx)
          NODE_M_BOT: begin
            nw = fx_mul(m, UNIT - ss, FRAC_BITS + 1);
            nr = fx_mul(-rr, UNIT - ss, FRAC_BITS);
            ns = round_shift(-m, 1);
          end
          NODE_M_RGT: begin
            nw = fx_mul(UNIT + rr, n, FRAC_BITS + 1);
            nr = round_shift(n, 1);
            ns = fx_mul(-ss, UNIT + rr, FRAC_BITS);
          end
          NODE_M_TOP: begin
            nw = fx_mul(m, UNIT + ss, FRAC_BITS + 1);
            nr = fx_mul(-rr, UNIT + ss, FRAC_BITS);
            ns = round_shift(m, 1);
          end
          default: begin
            nw = fx_mul(UNIT - rr, n, FRAC_BITS + 1);
            nr = round_shift(-n, 1);
            ns = fx_mul(-ss, UNIT - rr, FRAC_BITS);
          end
        endcase
      end
      w.idx    = idx;
      w.weight = clamp_out(nw);
      w.dr     = clamp_out(nr);
      w.ds     = clamp_out(ns);
      w.last   = (idx == NODE_LAST);
      node_exp_q.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    node_word_t want;
    if (rst_ni) begin
      if (point_i.valid && point_i.ready) begin
        predict_shape_set(point_i.pcoord_r, point_i.pcoord_s);
      end
      if (node_i.valid && node_i.ready) begin
        if (node_exp_q.size() == 0) begin
          $error("node word %0d with no point pending", node_i.node_index);
          fails++;
        end else begin
          want = node_exp_q.pop_front();
          if (node_i.node_index !== want.idx) begin
            $error("node_index expected %0d got %0d", want.idx, node_i.node_index);
            fails++;
          end
          if (node_i.node_weight !== want.weight) begin
            $error("node_weight expected %0d got %0d", want.weight, node_i.node_weight);
            fails++;
          end
          if (node_i.deriv_r !== want.dr) begin
            $error("deriv_r expected %0d got %0d", want.dr, node_i.deriv_r);
            fails++;
          end
          if (node_i.deriv_s !== want.ds) begin
            $error("deriv_s expected %0d got %0d", want.ds, node_i.deriv_s);
            fails++;
          end
          if (node_i.last_node !== want.last) begin
            $error("last_node expected %0d got %0d", want.last, node_i.last_node);
            fails++;
          end
        end
      end
    end
    pending_o    <= node_exp_q.size();
    fail_count_o <= fails;
  end

endmodule

>>> tb/sv/quad8_shape_functions_tb.sv
`timescale 1ns / 1ps

module quad8_shape_functions_tb;
  import q8sf_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int UNIT       = 1 << FRAC_BITS;
  localparam int N_RANDOM   = 160;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 20;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  logic [IN_W-1:0] pt_r_q[$];
  logic [IN_W-1:0] pt_s_q[$];

  q8sf_point_if point_ch();
  q8sf_node_if  node_ch();

  quad8_shape_functions #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(point_ch),
    .node_o (node_ch)
  );

  q8sf_node_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_ch),
    .node_i      (node_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic add_point(input int r, input int s);
    pt_r_q.push_back(IN_W'(r));
    pt_s_q.push_back(IN_W'(s));
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, (1 << IN_W) - 1);
      1: begin
        case ($urandom_range(0, 4))
          0: return 0;
          1: return UNIT;
          2: return UNIT / 2;
          3: return 1;
          default: return UNIT - 1;
        endcase
      end
      default: return $urandom_range(0, UNIT);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if ((point_ch.valid && point_ch.ready) || (node_ch.valid && node_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: segments of free, coin-flip and sparse ready, one long hold-off
  initial begin : sink_side
    rx_mode_e mode;
    int       seg_len;
    int       seg_no;
    seg_no = 0;
    node_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (seg_no == 3) begin
        node_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 2));
        seg_len = $urandom_range(10, 60);
        for (int c = 0; c < seg_len; c++) begin
          case (mode)
            RX_FREE:  node_ch.ready <= 1'b1;
            RX_COIN:  node_ch.ready <= 1'($urandom_range(0, 1));
            default:  node_ch.ready <= (c % 4 == 0);
          endcase
          @(posedge clk_i);
        end
      end
      seg_no++;
    end
  end

  initial begin : source_side
    int burst_left;
    int gap;
    rst_ni            <= 1'b0;
    point_ch.valid    <= 1'b0;
    point_ch.pcoord_r <= '0;
    point_ch.pcoord_s <= '0;

    // corners, mid-edges, center, saturation and rounding corners
    add_point(0, 0);
    add_point(UNIT, 0);
    add_point(UNIT, UNIT);
    add_point(0, UNIT);
    add_point(UNIT / 2, 0);
    add_point(UNIT, UNIT / 2);
    add_point(UNIT / 2, UNIT);
    add_point(0, UNIT / 2);
    add_point(UNIT / 2, UNIT / 2);
    add_point(UNIT + 1, 0);
    add_point(0, UNIT + 1);
    add_point((1 << IN_W) - 1, (1 << IN_W) - 1);
    add_point((1 << IN_W) - 1, 12345);
    add_point(1, 1);
    add_point(UNIT - 1, UNIT - 1);
    add_point(UNIT / 2 - 1, UNIT / 2 + 1);
    add_point(UNIT / 4, 3 * UNIT / 4);
    add_point(1, UNIT - 1);
    add_point(21845, 43690);
    add_point(100000, 70000);
    add_point(3, 65533);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_point(pick_coord(), pick_coord());
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < pt_r_q.size(); i++) begin
      point_ch.valid    <= 1'b1;
      point_ch.pcoord_r <= pt_r_q[i];
      point_ch.pcoord_s <= pt_s_q[i];
      @(posedge clk_i);
      while (!point_ch.ready) @(posedge clk_i);
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          point_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 16);
      end
    end
    point_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
